[design/aes_block_encrypt_top_macros.svh]
// ---------------------------------------------------------------------------
// AES block encrypt assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef AES_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES_BLOCK_ENCRYPT_TOP_MACROS_SVH

// check a property outside of reset
`define AESBE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every edge, reset included
`define AESBE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/aesbe_pkg.sv]
// ---------------------------------------------------------------------------
// AES block encrypt package
// Payload types, register indexes and the byte-level AES primitives.
// ---------------------------------------------------------------------------
package aesbe_pkg;

   typedef struct packed {
      logic [63:0] plaintext_high;
      logic [63:0] plaintext_low;
   } block_in_type;

   typedef struct packed {
      logic [63:0] ciphertext_high;
      logic [63:0] ciphertext_low;
   } block_out_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ks_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_ROUND
   } ctrl_state_type;

   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1b;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

[design/aesbe_column_cell.sv]
// ---------------------------------------------------------------------------
// AES column cell
// Holds one state column; each round takes its shifted bytes from the
// neighbor columns, substitutes, mixes (not the last round), adds the key.
// ---------------------------------------------------------------------------
module aesbe_column_cell (
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] load_col,
   input  logic        advance,
   input  logic [31:0] shift_in,
   input  logic [31:0] key_word,
   input  logic        last,
   output logic [31:0] col
);
   logic [31:0] col_ff, col_in;
   logic [7:0]  s0, s1, s2, s3, all;
   logic [31:0] mixed;

   always_comb begin
      s0 = aesbe_pkg::SBOX[shift_in[31:24]];
      s1 = aesbe_pkg::SBOX[shift_in[23:16]];
      s2 = aesbe_pkg::SBOX[shift_in[15:8]];
      s3 = aesbe_pkg::SBOX[shift_in[7:0]];
      all = s0 ^ s1 ^ s2 ^ s3;
      mixed = {s0 ^ all ^ aesbe_pkg::xtime(s0 ^ s1),
               s1 ^ all ^ aesbe_pkg::xtime(s1 ^ s2),
               s2 ^ all ^ aesbe_pkg::xtime(s2 ^ s3),
               s3 ^ all ^ aesbe_pkg::xtime(s3 ^ s0)};
      col_in = col_ff;
      if (load) begin
         col_in = load_col;
      end else if (advance) begin
         col_in = (last ? {s0, s1, s2, s3} : mixed) ^ key_word;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col = col_ff;
endmodule

[design/aesbe_key_sched.sv]
// ---------------------------------------------------------------------------
// AES key schedule
// Expands the key one word per cycle into a round-key memory of 128-bit rows.
// ---------------------------------------------------------------------------
module aesbe_key_sched #(
   parameter int ROWS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [1:0]                 code,
   input  logic [255:0]               key,
   input  logic [$clog2(ROWS)-1:0]    rd_addr,
   output logic [127:0]               rd_data,
   output aesbe_pkg::ks_status_type   status
);
   localparam int IW = $clog2(4 * ROWS);
   localparam int RW = $clog2(ROWS);

   logic [127:0]  mem [ROWS];
   logic [127:0]  rd_data_ff;
   logic [31:0]   win_ff [8];
   logic [IW-1:0] idx_ff, idx_in;
   logic [2:0]    mod_ff, mod_in;
   logic [7:0]    rcon_ff, rcon_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [2:0]    nk_m1;
   logic [IW-1:0] last_idx;
   logic [31:0]   prev, old, word;
   logic          in_key;

   always_comb begin
      case (code)
         aesbe_pkg::KEY_128: begin
            nk_m1 = 3'd3;
            old = win_ff[4];
         end
         aesbe_pkg::KEY_192: begin
            nk_m1 = 3'd5;
            old = win_ff[2];
         end
         default: begin
            nk_m1 = 3'd7;
            old = win_ff[0];
         end
      endcase
      // total words = 4 * (nk + 7)
      last_idx = IW'((32'(nk_m1) + 32'd8) * 32'd4 - 32'd1);
      prev = win_ff[7];
      in_key = (idx_ff <= IW'(nk_m1));
      if (in_key) begin
         word = key[255 - 32 * idx_ff[2:0] -: 32];
      end else if (mod_ff == 3'd0) begin
         word = aesbe_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_ff, 24'h0} ^ old;
      end else if (nk_m1 == 3'd7 && mod_ff == 3'd4) begin
         word = aesbe_pkg::sub_word(prev) ^ old;
      end else begin
         word = prev ^ old;
      end

      idx_in = idx_ff;
      mod_in = mod_ff;
      rcon_in = rcon_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (go) begin
         idx_in = '0;
         mod_in = '0;
         rcon_in = aesbe_pkg::RCON_FIRST;
         run_in = 1'b1;
      end else if (run_ff) begin
         idx_in = idx_ff + 1'b1;
         mod_in = (mod_ff == nk_m1) ? 3'd0 : mod_ff + 3'd1;
         if (!in_key && mod_ff == 3'd0) begin
            rcon_in = aesbe_pkg::xtime(rcon_ff);
         end
         if (idx_ff == last_idx) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      mod_ff <= mod_in;
      rcon_ff <= rcon_in;
   end

   // shift window: slot 7 holds the newest word
   always_ff @(posedge clock) begin
      if (run_ff && !go) begin
         for (int k = 0; k < 7; k++) begin
            win_ff[k] <= win_ff[k + 1];
         end
         win_ff[7] <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (run_ff && !go && idx_ff[IW-1:2] < RW'(ROWS)) begin
         mem[idx_ff[IW-1:2]][127 - 32 * idx_ff[1:0] -: 32] <= word;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign status.busy = run_ff;
   assign status.done = done_ff;
endmodule

[design/aes_block_encrypt_top.sv]
// ---------------------------------------------------------------------------
// AES block encrypt top level
// FIPS-197 encryption of one 128-bit block per request.
// ---------------------------------------------------------------------------
// Usage:
//  - Configuration: APB-style port, registers at byte address 8*i
//    (key_size, key_word_0..3), 64-bit data, pready tied high.
//  - Any register write marks the schedule stale. While stale the block
//    raises busy and expands the key, one round-key word per cycle: 44,
//    52 or 60 words for 128, 192 or 256 bit keys. Busy holds until the
//    expansion is done; a write during it restarts the expansion.
//  - Request: a block is taken at a clock edge with start high and busy
//    low. Busy stays high while rounds run.
//  - Rounds: Nr rounds (10, 12 or 14), one per cycle in the column
//    cells; rsp_valid pulses the cycle after the last round.
//  - Blocks: one at a time; a new block is taken only once the last round
//    of the one before is done in the four column cells.
//  - The response shows for exactly one cycle; the receiver cannot stall.
//  - Reset clears the key registers to zero and marks the schedule stale,
//    so the first expansion starts right after reset.
// ---------------------------------------------------------------------------
module aes_block_encrypt_top #(
   parameter int MAX_ROUNDS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  aesbe_pkg::block_in_type   req_data,
   output logic                      rsp_valid,
   output aesbe_pkg::block_out_type  rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [5:0]                paddr,
   input  logic [63:0]               pwdata,
   output logic [63:0]               prdata,
   output logic                      pready
);
   localparam int ROWS = MAX_ROUNDS + 1;
   localparam int RW   = $clog2(ROWS);

   // configuration registers
   logic [1:0]  key_size_ff;
   logic [63:0] key_ff [4];
   logic        cfg_wr;
   logic [2:0]  cfg_idx;

   // control
   aesbe_pkg::ctrl_state_type state_ff, state_in;
   logic            stale_ff, stale_in;
   logic [RW-1:0]   round_ff, round_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            ks_go, accept, last;
   logic [1:0]      code;
   logic [RW-1:0]   num_rounds;
   logic [RW-1:0]   rd_addr;
   logic [127:0]    rd_data;
   aesbe_pkg::ks_status_type ks_status;

   // datapath
   logic [127:0] block_in;
   logic [31:0]  cols [4];
   logic [31:0]  shifted [4];

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= 2'd0;
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= 64'd0;
         end
      end else if (cfg_wr) begin
         case (cfg_idx)
            aesbe_pkg::CSR_KEY_SIZE:   key_size_ff <= pwdata[1:0];
            aesbe_pkg::CSR_KEY_WORD_0: key_ff[0] <= pwdata;
            aesbe_pkg::CSR_KEY_WORD_1: key_ff[1] <= pwdata;
            aesbe_pkg::CSR_KEY_WORD_2: key_ff[2] <= pwdata;
            aesbe_pkg::CSR_KEY_WORD_3: key_ff[3] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         aesbe_pkg::CSR_KEY_SIZE:   prdata = {62'd0, key_size_ff};
         aesbe_pkg::CSR_KEY_WORD_0: prdata = key_ff[0];
         aesbe_pkg::CSR_KEY_WORD_1: prdata = key_ff[1];
         aesbe_pkg::CSR_KEY_WORD_2: prdata = key_ff[2];
         aesbe_pkg::CSR_KEY_WORD_3: prdata = key_ff[3];
         default:                   prdata = 64'd0;
      endcase
   end

   // saturate code three to the 256 bit size
   assign code = (key_size_ff == 2'd3) ? aesbe_pkg::KEY_256 : key_size_ff;

   always_comb begin
      case (code)
         aesbe_pkg::KEY_128: num_rounds = RW'(10);
         aesbe_pkg::KEY_192: num_rounds = RW'(12);
         default:            num_rounds = RW'(14);
      endcase
      if (num_rounds > RW'(MAX_ROUNDS)) begin
         num_rounds = RW'(MAX_ROUNDS);
      end
   end

   assign busy   = (state_ff != aesbe_pkg::ST_IDLE) || stale_ff;
   assign accept = start && !busy;
   assign last   = (round_ff == num_rounds);

   always_comb begin
      state_in = state_ff;
      stale_in = stale_ff;
      round_in = round_ff;
      rsp_valid_in = 1'b0;
      ks_go = 1'b0;
      rd_addr = '0;
      case (state_ff)
         aesbe_pkg::ST_IDLE: begin
            if (stale_ff) begin
               // kick the schedule; restart drops any stale run
               ks_go = 1'b1;
               stale_in = 1'b0;
               state_in = aesbe_pkg::ST_EXPAND;
            end else if (accept) begin
               round_in = RW'(1);
               rd_addr = RW'(1);
               state_in = aesbe_pkg::ST_ROUND;
            end
         end
         aesbe_pkg::ST_EXPAND: begin
            if (ks_status.done) begin
               state_in = aesbe_pkg::ST_IDLE;
            end
         end
         aesbe_pkg::ST_ROUND: begin
            if (last) begin
               rsp_valid_in = 1'b1;
               state_in = aesbe_pkg::ST_IDLE;
            end else begin
               round_in = round_ff + 1'b1;
               rd_addr = round_ff + 1'b1;
            end
         end
         default: begin
            state_in = aesbe_pkg::ST_IDLE;
         end
      endcase
      // a register write abandons any expansion or block in flight
      if (cfg_wr) begin
         stale_in = 1'b1;
         state_in = aesbe_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aesbe_pkg::ST_IDLE;
         stale_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stale_ff <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      round_ff <= round_in;
   end

   aesbe_key_sched #(
      .ROWS (ROWS)
   ) u_key_sched (
      .clock   (clock),
      .reset   (reset),
      .go      (ks_go),
      .code    (code),
      .key     ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .status  (ks_status)
   );

   assign block_in = {req_data.plaintext_high, req_data.plaintext_low};

   // row r of column c comes from column c+r: the ShiftRows handoff
   for (genvar c = 0; c < 4; c++) begin : g_cell
      for (genvar r = 0; r < 4; r++) begin : g_row
         assign shifted[c][31 - 8 * r -: 8] = cols[(c + r) % 4][31 - 8 * r -: 8];
      end
      aesbe_column_cell u_cell (
         .clock    (clock),
         .load     (accept),
         .load_col (block_in[127 - 32 * c -: 32] ^ rd_data[127 - 32 * c -: 32]),
         .advance  (state_ff == aesbe_pkg::ST_ROUND),
         .shift_in (shifted[c]),
         .key_word (rd_data[127 - 32 * c -: 32]),
         .last     (last),
         .col      (cols[c])
      );
   end

   // columns hold until the next request loads them
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.ciphertext_high = {cols[0], cols[1]};
   assign rsp_data.ciphertext_low  = {cols[2], cols[3]};
endmodule

[design/aesbe_checker.sv]
// ---------------------------------------------------------------------------
// AES block encrypt checker
// Port-level checks of the request and response timing, reset state and pready.
// ---------------------------------------------------------------------------
`include "aes_block_encrypt_top_macros.svh"

module aesbe_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic pready
);
   `AESBE_ASSERT(a_take_sets_busy, (start && !busy) |=> busy, "busy low after request")
   `AESBE_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "response longer than one cycle")
   `AESBE_ASSERT(a_rsp_after_busy, rsp_valid |-> $past(busy), "response without work")
   `AESBE_ASSERT_ALWAYS(a_reset_state, reset |=> (busy && !rsp_valid), "bad state after reset")
   `AESBE_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
endmodule

bind aes_block_encrypt_top aesbe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .pready    (pready)
);
